### src/trpp_pkg.sv
// ----------------------------------------------------------------------------
// trpp_pkg
// Shared types, constants and the status code mapping for the time-of-flight
// range result post-processor.
// ----------------------------------------------------------------------------
package trpp_pkg;

	localparam int GAIN_W      = 11;
	localparam int GAIN_SHIFT  = 11;
	localparam int RATE_W      = 16;
	localparam int STATUS_W    = 4;

	localparam logic [26:0] ROUND_HALF    = 27'h0000400;
	localparam logic [15:0] CLIP16        = 16'hFFFF;
	localparam logic [15:0] SPAD_MIDPOINT = 16'h8000;
	localparam logic [15:0] TARGET_RESET  = 16'h0A00;
	localparam logic [10:0] GAIN_RESET    = 11'd2011;

	localparam logic REG_TARGET_RATE = 1'b0;
	localparam logic REG_RANGE_GAIN  = 1'b1;

	typedef enum logic [3:0] {
		ST_NONE        = 4'd0,
		ST_HW_FAIL     = 4'd1,
		ST_MIN_RANGE   = 4'd2,
		ST_SYNC        = 4'd3,
		ST_OUT_OF_BND  = 4'd4,
		ST_SIGNAL_FAIL = 4'd5,
		ST_SIGMA_FAIL  = 4'd6,
		ST_WRAP_FAIL   = 4'd7,
		ST_XTALK_FAIL  = 4'd8,
		ST_MIN_CLIPPED = 4'd9,
		ST_NO_WRAP     = 4'd10,
		ST_VALID       = 4'd11
	} status_t;

	typedef struct packed {
		logic [15:0] scaled_mm;
		logic [3:0]  status_code;
		logic        spads_zero;
	} rate_side_t;

	typedef struct packed {
		logic [15:0] scaled_mm;
		logic [3:0]  status_code;
	} req_side_t;

	function automatic status_t map_status(input logic [7:0] code, input logic [7:0] stream);
		status_t res;
		begin
			case (code)
				8'd1, 8'd2, 8'd3, 8'd17: res = ST_HW_FAIL;
				8'd13: res = ST_MIN_RANGE;
				8'd18: res = ST_SYNC;
				8'd5: res = ST_OUT_OF_BND;
				8'd4: res = ST_SIGNAL_FAIL;
				8'd6: res = ST_SIGMA_FAIL;
				8'd7: res = ST_WRAP_FAIL;
				8'd12: res = ST_XTALK_FAIL;
				8'd8: res = ST_MIN_CLIPPED;
				8'd9: res = (stream == 8'd0) ? ST_NO_WRAP : ST_VALID;
				default: res = ST_NONE;
			endcase
			return res;
		end
	endfunction

endpackage

### src/trpp_rate_div.sv
// ----------------------------------------------------------------------------
// trpp_rate_div
// Pipelined restoring divider, one quotient bit per stage, that forms the
// count rate per SPAD as (rate_sum << 16) / spads. Side data travels along.
// ----------------------------------------------------------------------------
module trpp_rate_div
	import trpp_pkg::*;
#(
	parameter int SIDE_W = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [15:0]       rate_sum,
	input  logic [15:0]       spads,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [31:0]       per_spad,
	output logic [SIDE_W-1:0] out_side
);

	localparam int N = 32;

	logic              v_s    [0:N-1];
	logic [15:0]       rem_s  [0:N-1];
	logic [31:0]       num_s  [0:N-1];
	logic [15:0]       div_s  [0:N-1];
	logic [SIDE_W-1:0] side_s [0:N-1];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic              v_in;
		logic [15:0]       r_in;
		logic [31:0]       n_in;
		logic [15:0]       d_in;
		logic [SIDE_W-1:0] sd_in;
		logic [16:0]       r2;
		logic [15:0]       diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = 16'd0;
			assign n_in  = {rate_sum, 16'd0};
			assign d_in  = spads;
			assign sd_in = in_side;
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign r_in  = rem_s[k-1];
			assign n_in  = num_s[k-1];
			assign d_in  = div_s[k-1];
			assign sd_in = side_s[k-1];
		end

		assign r2   = {r_in, n_in[31]};
		assign diff = r2[15:0] - d_in;
		assign ge   = (r2 >= {1'b0, d_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff : r2[15:0];
				num_s[k]  <= {n_in[30:0], ge};
				div_s[k]  <= d_in;
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign per_spad  = num_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

### src/trpp_req_div.sv
// ----------------------------------------------------------------------------
// trpp_req_div
// Pipelined restoring divider for the SPAD request, (target << 16) / per_spad,
// with an overflow check up front that clips the result to 16 bits and the
// midpoint fallback applied at the end.
// ----------------------------------------------------------------------------
module trpp_req_div
	import trpp_pkg::*;
#(
	parameter int SIDE_W = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [15:0]       target,
	input  logic [31:0]       per_spad,
	input  logic              in_fallback,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [15:0]       request,
	output logic              fallback,
	output logic [SIDE_W-1:0] out_side
);

	localparam int N = 16;

	logic              v_pre_q;
	logic [31:0]       rem_pre_q;
	logic [31:0]       div_pre_q;
	logic              ovf_pre_q;
	logic              fb_pre_q;
	logic [SIDE_W-1:0] side_pre_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_pre_q <= 1'b0;
		end else if (en) begin
			v_pre_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_pre_q  <= {16'd0, target};
			div_pre_q  <= per_spad;
			ovf_pre_q  <= ({16'd0, target} >= per_spad);
			fb_pre_q   <= in_fallback;
			side_pre_q <= in_side;
		end
	end

	logic              v_s    [0:N-1];
	logic [31:0]       rem_s  [0:N-1];
	logic [15:0]       quo_s  [0:N-1];
	logic [31:0]       div_s  [0:N-1];
	logic              ovf_s  [0:N-1];
	logic              fb_s   [0:N-1];
	logic [SIDE_W-1:0] side_s [0:N-1];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic              v_in;
		logic [31:0]       r_in;
		logic [15:0]       q_in;
		logic [31:0]       d_in;
		logic              o_in;
		logic              f_in;
		logic [SIDE_W-1:0] sd_in;
		logic [32:0]       r2;
		logic [31:0]       diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in  = v_pre_q;
			assign r_in  = rem_pre_q;
			assign q_in  = 16'd0;
			assign d_in  = div_pre_q;
			assign o_in  = ovf_pre_q;
			assign f_in  = fb_pre_q;
			assign sd_in = side_pre_q;
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign r_in  = rem_s[k-1];
			assign q_in  = quo_s[k-1];
			assign d_in  = div_s[k-1];
			assign o_in  = ovf_s[k-1];
			assign f_in  = fb_s[k-1];
			assign sd_in = side_s[k-1];
		end

		assign r2   = {r_in, 1'b0};
		assign diff = r2[31:0] - d_in;
		assign ge   = (r2 >= {1'b0, d_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff : r2[31:0];
				quo_s[k]  <= {q_in[14:0], ge};
				div_s[k]  <= d_in;
				ovf_s[k]  <= o_in;
				fb_s[k]   <= f_in;
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign fallback  = fb_s[N-1];
	assign out_side  = side_s[N-1];
	assign request   = fb_s[N-1]  ? SPAD_MIDPOINT :
	                   ovf_s[N-1] ? CLIP16 : quo_s[N-1];

endmodule

### src/tof_range_result_postprocess_core.sv
// ----------------------------------------------------------------------------
// tof_range_result_postprocess_core
// Range gain correction, status code mapping and SPAD request computation for
// one time-of-flight result record per request.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle while the output is not stalled. The
// two bit-serial divider pipelines (32 and 16 stages) lie between the input
// and output registers, and the whole pipeline stalls together.
// Reset clears all valid bits and loads target_total_rate = 0x0A00 and
// range_gain = 2011.
module tof_range_result_postprocess_core
	import trpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// raw_status[7:0], stream_cnt[15:8], effective_spads[31:16],
	// ambient_rate[47:32], signal_rate[63:48], raw_range_mm[79:64]
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// scaled_mm[15:0], status_code[19:16], spad_request[35:20],
	// spad_fallback[36], zero[39:37]
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] target_q;
	logic [10:0] gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			gain_q   <= GAIN_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TARGET_RATE) begin
				target_q <= cfg_data;
			end else begin
				gain_q <= cfg_data[10:0];
			end
		end
	end

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [16:0] sum_full;
	assign sum_full = {1'b0, s_tdata[63:48]} + {1'b0, s_tdata[47:32]};

	logic        v_s1;
	logic [26:0] prod_s1;
	status_t     status_s1;
	logic [15:0] sum_s1;
	logic [15:0] spads_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1   <= {11'd0, s_tdata[79:64]} * {16'd0, gain_q};
			status_s1 <= map_status(s_tdata[7:0], s_tdata[15:8]);
			sum_s1    <= sum_full[16] ? CLIP16 : sum_full[15:0];
			spads_s1  <= s_tdata[31:16];
		end
	end

	logic [26:0] rounded;
	rate_side_t  side1_in;
	rate_side_t  side1_out;
	logic        v_d1;
	logic [31:0] per_spad;

	assign rounded              = prod_s1 + ROUND_HALF;
	assign side1_in.scaled_mm   = rounded[26:GAIN_SHIFT];
	assign side1_in.status_code = status_s1;
	assign side1_in.spads_zero  = (spads_s1 == 16'd0);

	trpp_rate_div #(
		.SIDE_W($bits(rate_side_t))
	) u_rate_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.rate_sum  (sum_s1),
		.spads     (spads_s1),
		.in_side   (side1_in),
		.out_valid (v_d1),
		.per_spad  (per_spad),
		.out_side  (side1_out)
	);

	req_side_t   side2_in;
	req_side_t   side2_out;
	logic        v_d2;
	logic [15:0] request;
	logic        fallback;

	assign side2_in.scaled_mm   = side1_out.scaled_mm;
	assign side2_in.status_code = side1_out.status_code;

	trpp_req_div #(
		.SIDE_W($bits(req_side_t))
	) u_req_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_d1),
		.target      (target_q),
		.per_spad    (per_spad),
		.in_fallback (side1_out.spads_zero || (per_spad == 32'd0)),
		.in_side     (side2_in),
		.out_valid   (v_d2),
		.request     (request),
		.fallback    (fallback),
		.out_side    (side2_out)
	);

	logic [39:0] out_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= {3'd0, fallback, request, side2_out.status_code, side2_out.scaled_mm};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_fallback_midpoint: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[36]) |-> (m_tdata[35:20] == SPAD_MIDPOINT))
		else $error("fallback result without midpoint request");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:16] <= ST_VALID))
		else $error("status code out of range");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while output stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:37] == 3'd0))
		else $error("output padding not zero");

endmodule
